// ===== sv/lbpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbpm_pkg
// Shared types, band bounds and the log-height table of the band peak meter.
// ----------------------------------------------------------------------------
package lbpm_pkg;

  localparam int NUM_BANDS  = 16;
  localparam int BAND_W     = 4;
  localparam int POS_W      = 8;
  localparam int MAG_W      = 16;
  localparam int PEAK_W     = 15;
  localparam int SHIFT_W    = 4;
  localparam int LEVEL_W    = 8;
  localparam int HEIGHT_W   = 12;
  localparam int COUNT_W    = 5;
  localparam int LOG_DEPTH  = 256;

  localparam logic [POS_W-1:0]   LAST_BIN    = 8'd255;
  localparam logic [BAND_W-1:0]  LAST_BAND   = 4'd15;
  localparam logic [COUNT_W-1:0] FULL_COUNT  = 5'd16;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd7;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;

  // Bin number that follows the last bin of each band, band 15 in the top byte.
  localparam logic [NUM_BANDS-1:0][POS_W-1:0] BAND_END = {
    8'd255, 8'd187, 8'd137, 8'd101, 8'd74, 8'd54, 8'd40, 8'd28,
    8'd20,  8'd14,  8'd10,  8'd7,   8'd5,  8'd3,  8'd2,  8'd1
  };

  typedef logic [LOG_DEPTH-1:0][HEIGHT_W-1:0] log_rom_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [PEAK_W-1:0] peak;
  } band_event_t;

  // 512*log2(p) by repeated squaring of a Q1.30 mantissa, rounded to 9 bits.
  function automatic logic [HEIGHT_W-1:0] log_height(input int p);
    int          k;
    int          frac;
    logic [63:0] m;
    k    = 0;
    frac = 0;
    if (p == 0) begin
      return '0;
    end
    for (int i = 0; i < 7; i++) begin
      if ((p >> (i + 1)) != 0) begin
        k = i + 1;
      end
    end
    m = 64'(p) << (30 - k);
    for (int i = 0; i < 12; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m    = m >> 1;
      end
    end
    return HEIGHT_W'(k * 512 + ((frac + 4) >> 3));
  endfunction

  function automatic log_rom_t build_log_rom();
    log_rom_t rom;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      rom[i] = log_height(i);
    end
    return rom;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

endpackage
`default_nettype wire

// ===== sv/lbpm_band_acc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbpm_band_acc
// Tracks the bin position and band, keeps the running positive peak, and
// registers a band event with its final peak at the last bin of each band.
// ----------------------------------------------------------------------------
module lbpm_band_acc (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_fire,
  input  wire logic [lbpm_pkg::MAG_W-1:0]  magnitude,
  output logic                             in_ready,
  output logic                             ev_valid,
  output lbpm_pkg::band_event_t            ev,
  input  wire logic                        ev_ready
);
  import lbpm_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;
  logic [PEAK_W-1:0] peak_r, peak_nxt;
  logic              ev_valid_r, ev_valid_nxt;
  band_event_t       ev_r, ev_nxt;
  logic [PEAK_W-1:0] peak_upd;
  logic              band_end;

  assign in_ready = !ev_valid_r || ev_ready;
  assign ev_valid = ev_valid_r;
  assign ev       = ev_r;

  always_comb begin
    peak_upd = peak_r;
    if (!magnitude[MAG_W-1] && (magnitude[PEAK_W-1:0] > peak_r)) begin
      peak_upd = magnitude[PEAK_W-1:0];
    end
    band_end     = (pos_r != LAST_BIN) && ((pos_r + 8'd1) == BAND_END[band_r]);
    pos_nxt      = pos_r;
    band_nxt     = band_r;
    peak_nxt     = peak_r;
    ev_nxt       = ev_r;
    ev_valid_nxt = ev_valid_r && !ev_ready;
    if (in_fire) begin
      if (pos_r == LAST_BIN) begin
        pos_nxt  = '0;
        band_nxt = '0;
        peak_nxt = '0;
      end else if (band_end) begin
        pos_nxt      = pos_r + 8'd1;
        band_nxt     = band_r + 4'd1;
        peak_nxt     = '0;
        ev_valid_nxt = 1'b1;
        ev_nxt.band  = band_r;
        ev_nxt.peak  = peak_upd;
      end else begin
        pos_nxt  = pos_r + 8'd1;
        peak_nxt = peak_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      band_r     <= '0;
      peak_r     <= '0;
      ev_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      band_r     <= band_nxt;
      peak_r     <= peak_nxt;
      ev_valid_r <= ev_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/lbpm_height.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbpm_height
// Shifts and saturates a band peak, looks up its log height, counts the
// non-empty bands of the frame and holds the result in the output register.
// ----------------------------------------------------------------------------
module lbpm_height (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [lbpm_pkg::SHIFT_W-1:0]  peak_shift,
  input  wire logic                          ev_valid,
  input  wire lbpm_pkg::band_event_t         ev,
  output logic                               ev_ready,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic [lbpm_pkg::BAND_W-1:0]        band_index,
  output logic [lbpm_pkg::HEIGHT_W-1:0]      band_height,
  output logic                               band_empty,
  output logic                               frame_done,
  output logic [lbpm_pkg::COUNT_W-1:0]       active_bands
);
  import lbpm_pkg::*;

  logic                  res_valid_r, res_valid_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [BAND_W-1:0]     band_r;
  logic [HEIGHT_W-1:0]   height_r;
  logic                  empty_r;
  logic                  done_r;
  logic [COUNT_W-1:0]    active_r;
  logic [PEAK_W-1:0]     shifted;
  logic [LEVEL_W-1:0]    level;
  logic                  empty;
  logic                  done;
  logic [COUNT_W-1:0]    cnt_dec;
  logic                  take;

  assign ev_ready     = !res_valid_r || res_ready;
  assign take         = ev_valid && ev_ready;
  assign res_valid    = res_valid_r;
  assign band_index   = band_r;
  assign band_height  = height_r;
  assign band_empty   = empty_r;
  assign frame_done   = done_r;
  assign active_bands = active_r;

  always_comb begin
    shifted = ev.peak >> peak_shift;
    level   = (|shifted[PEAK_W-1:LEVEL_W]) ? LEVEL_MAX : shifted[LEVEL_W-1:0];
    empty   = (level == '0);
    done    = (ev.band == LAST_BAND);
    cnt_dec = (empty && (cnt_r != '0)) ? cnt_r - 5'd1 : cnt_r;
    cnt_nxt = cnt_r;
    if (take) begin
      cnt_nxt = done ? FULL_COUNT : cnt_dec;
    end
    res_valid_nxt = take || (res_valid_r && !res_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      cnt_r       <= FULL_COUNT;
    end else begin
      res_valid_r <= res_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      band_r   <= ev.band;
      height_r <= LOG_ROM[level];
      empty_r  <= empty;
      done_r   <= done;
      active_r <= done ? cnt_dec : '0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/log_band_peak_meter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// log_band_peak_meter_core
// Sixteen-band logarithmic spectrum peak meter with log-compressed heights.
// ----------------------------------------------------------------------------
// One signed magnitude is taken per cycle, 256 bins to a frame, counted from
// reset; bin 255 is ignored. The result of each band is registered in ev_r and
// then in the output register, and a new bin is accepted in every cycle while
// the output register is empty or being drained; the input stalls only while
// a band result is held untaken in the output register and a second one waits
// behind it. The last band of a frame carries tlast and the non-empty count.
module log_band_peak_meter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,     // peak_shift
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,      // [15:0] magnitude
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,     // [3:0] band_index, [15:4] band_height,
                                          // [20:16] active_bands, [23:21] zero
  output logic             out_tuser,     // band_empty
  output logic             out_tlast      // frame_done
);
  import lbpm_pkg::*;

  logic [SHIFT_W-1:0]  shift_r;
  logic                in_fire;
  logic                ev_valid;
  logic                ev_ready;
  band_event_t         ev;
  logic [BAND_W-1:0]   band_index;
  logic [HEIGHT_W-1:0] band_height;
  logic [COUNT_W-1:0]  active_bands;

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= SHIFT_RESET;
    end else if (cfg_we) begin
      shift_r <= cfg_wdata;
    end
  end

  lbpm_band_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .magnitude (in_tdata),
    .in_ready  (in_tready),
    .ev_valid  (ev_valid),
    .ev        (ev),
    .ev_ready  (ev_ready)
  );

  lbpm_height u_height (
    .clk          (clk),
    .rst_n        (rst_n),
    .peak_shift   (shift_r),
    .ev_valid     (ev_valid),
    .ev           (ev),
    .ev_ready     (ev_ready),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .band_index   (band_index),
    .band_height  (band_height),
    .band_empty   (out_tuser),
    .frame_done   (out_tlast),
    .active_bands (active_bands)
  );

  assign out_tdata = {3'b000, active_bands, band_height, band_index};

`ifndef ASSERT_OFF
  a_last_is_band15: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> band_index == LAST_BAND)
    else $error("frame end flagged on a band other than the last");

  a_empty_zero_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> band_height == '0)
    else $error("empty band with non-zero height");

  a_active_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> active_bands == '0)
    else $error("active band count reported before frame end");

  a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> active_bands <= FULL_COUNT)
    else $error("active band count out of range");
`endif

endmodule
`default_nettype wire

// ===== test/tb_log_band_peak_meter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_log_band_peak_meter_core
// Self-checking bench for the sixteen-band logarithmic peak meter.
// ----------------------------------------------------------------------------
// Streams spectrum bins into the meter and tracks bin position, band peaks and
// the non-empty count alongside it, so that every band result can be predicted
// and compared field by field in arrival order. A short directed frame opening
// comes first, then random frames of varying density under several peak shift
// settings, with the sender and receiver idling at different rates.
module tb_log_band_peak_meter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lbpm_pkg::*;

  localparam int           PHASES      = 6;
  localparam int           PHASE_BINS  = 320;
  localparam int           QUIET_TICKS = 8;
  localparam int           STALL_LIMIT = 4000;
  localparam int unsigned  BAND_STOP [NUM_BANDS] = '{
    1, 2, 3, 5, 7, 10, 14, 20, 28, 40, 54, 74, 101, 137, 187, 255
  };
  localparam logic [15:0]  OPENING [25] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'h0080, 16'h00FF, 16'h0100, 16'hFFFF,
    16'h4000, 16'h0001, 16'hC000, 16'h0000, 16'h007F, 16'h8001, 16'h0040,
    16'h7F80, 16'h2AAA, 16'h5555, 16'hFFFE, 16'h0001, 16'h3FFF, 16'h00FF,
    16'h0180, 16'h7FFE, 16'h8000, 16'h1234
  };

  typedef struct {
    logic [3:0]          band_idx;
    logic [HEIGHT_W-1:0] height;
    logic                empty;
    logic                last;
    logic [COUNT_W-1:0]  active;
  } band_result_t;

  class band_peak_tracker;
    logic [3:0]         shift_amt;
    logic [7:0]         bin_pos;
    logic [3:0]         band_no;
    logic [14:0]        peak_hold;
    logic [COUNT_W-1:0] lit_count;
    band_result_t       due_bands[$];
    int                 faults;

    function new();
      shift_amt = SHIFT_RESET;
      bin_pos   = '0;
      band_no   = '0;
      peak_hold = '0;
      lit_count = FULL_COUNT;
      faults    = 0;
    endfunction

    function void set_shift(logic [3:0] v);
      shift_amt = v;
    endfunction

    function int pending();
      return due_bands.size();
    endfunction

    // Height is 512*log2(level): integer part from the top set bit, twelve
    // fraction bits by squaring a Q1.30 mantissa, then rounded to nine bits.
    function logic [HEIGHT_W-1:0] level_to_height(logic [7:0] level);
      int unsigned whole;
      int unsigned bits;
      logic [63:0] mant;
      whole = 0;
      bits  = 0;
      if (level == 0) begin
        return '0;
      end
      for (int j = 0; j < 8; j++) begin
        if (level[j]) begin
          whole = j;
        end
      end
      mant = 64'(level) << (30 - whole);
      for (int j = 0; j < 12; j++) begin
        mant = (mant * mant) >> 30;
        bits = bits << 1;
        if (mant >= 64'h8000_0000) begin
          bits = bits | 1;
          mant = mant >> 1;
        end
      end
      return HEIGHT_W'(whole * 512 + ((bits + 4) >> 3));
    endfunction

    function void take_bin(logic [15:0] mag);
      logic [14:0]  shifted;
      logic [7:0]   level;
      band_result_t r;
      if (bin_pos == LAST_BIN) begin
        bin_pos   = '0;
        band_no   = '0;
        peak_hold = '0;
        return;
      end
      if (!mag[15] && mag[14:0] > peak_hold) begin
        peak_hold = mag[14:0];
      end
      bin_pos = bin_pos + 8'd1;
      if (bin_pos != 8'(BAND_STOP[band_no])) begin
        return;
      end
      shifted = peak_hold >> shift_amt;
      level   = (shifted > 15'(LEVEL_MAX)) ? LEVEL_MAX : shifted[7:0];
      r.band_idx = band_no;
      r.empty    = (level == 0);
      if (r.empty) begin
        r.height = '0;
        if (lit_count > 0) begin
          lit_count = lit_count - 1'b1;
        end
      end else begin
        r.height = level_to_height(level);
      end
      r.last   = (band_no == LAST_BAND);
      r.active = r.last ? lit_count : '0;
      due_bands.push_back(r);
      peak_hold = '0;
      band_no   = band_no + 4'd1;
      if (r.last) begin
        lit_count = FULL_COUNT;
      end
    endfunction

    function void check_band(logic [23:0] data, logic empty_flag, logic done_flag);
      band_result_t want;
      if (due_bands.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("unexpected band result: tdata=%h tuser=%b tlast=%b",
                   data, empty_flag, done_flag);
        end
        return;
      end
      want = due_bands.pop_front();
      if (data[3:0] !== want.band_idx || data[15:4] !== want.height ||
          data[20:16] !== want.active || data[23:21] !== 3'b000 ||
          empty_flag !== want.empty || done_flag !== want.last) begin
        faults++;
        if (faults <= 10) begin
          $display("band mismatch: expected band %0d height %0d empty %0b done %0b active %0d",
                   want.band_idx, want.height, want.empty, want.last, want.active);
          $display("               got band %0d height %0d empty %0b done %0b active %0d pad %0d",
                   data[3:0], data[15:4], empty_flag, done_flag, data[20:16], data[23:21]);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  band_peak_tracker tracker;
  int               in_idle_pct;
  int               out_idle_pct;
  int               frame_density;
  int unsigned      sent_bins;
  int               stall_ticks;
  logic [3:0]       shift_plan [PHASES];

  log_band_peak_meter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_band(out_tdata, out_tuser, out_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_ticks <= 0;
    end else if (stall_ticks >= STALL_LIMIT) begin
      $display("tb_log_band_peak_meter_core: FAIL");
      $finish;
    end else begin
      stall_ticks <= stall_ticks + 1;
    end
  end

  function automatic logic [15:0] pick_magnitude();
    logic [15:0] v;
    if ($urandom_range(0, 99) < frame_density) begin
      case ($urandom_range(0, 5))
        0: v = 16'h7FFF;
        1: v = 16'h0001;
        default: v = {1'b0, 15'($urandom_range(1, 32767) >> $urandom_range(0, 14))};
      endcase
      if (v == 16'h0000) begin
        v = 16'h0001;
      end
    end else begin
      case ($urandom_range(0, 3))
        0: v = 16'h0000;
        1: v = 16'hFFFF;
        2: v = 16'h8000;
        default: v = {1'b1, 15'($urandom())};
      endcase
    end
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_bin(input logic [15:0] mag);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= mag;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    tracker.take_bin(mag);
    sent_bins++;
    @(negedge clk);
  endtask

  task automatic settle();
    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
    repeat (QUIET_TICKS) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_shift(input logic [3:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    tracker.set_shift(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    tracker       = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    in_idle_pct   = 15;
    out_idle_pct  = 88;
    frame_density = 50;
    sent_bins     = 0;
    stall_ticks   = 0;
    shift_plan    = '{4'd0, 4'd15, 4'd4, 4'd9, SHIFT_RESET, 4'($urandom_range(1, 14))};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (OPENING[i]) begin
      send_bin(OPENING[i]);
    end
    in_tvalid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      in_idle_pct  = (ph < 2) ? 15 : (ph < 4) ? 88 : 0;
      out_idle_pct = (ph < 2) ? 88 : (ph < 4) ? 15 : 0;
      settle();
      write_shift(shift_plan[ph]);
      repeat (PHASE_BINS) begin
        if (sent_bins % 256 == 0) begin
          case ($urandom_range(0, 3))
            0: frame_density = 0;
            1: frame_density = 100;
            default: frame_density = $urandom_range(5, 95);
          endcase
        end
        send_bin(pick_magnitude());
      end
      in_tvalid <= 1'b0;
    end

    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("tb_log_band_peak_meter_core: PASS");
    end else begin
      $display("tb_log_band_peak_meter_core: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
